FILE: sv/ksu_pkg.sv
// ----------------------------------------------------------------------------
// ksu_pkg: shared types and constants of the keyed entry sorter
// Holds store sizes, status codes, controller/datapath command and status
// structs and the key ordering function.
// ----------------------------------------------------------------------------
package ksu_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int KEY_BYTES   = 8;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int KEY_W       = 64;
  localparam int REC_W       = 32;
  localparam int ENT_W       = KEY_W + REC_W;

  typedef enum logic [1:0] {
    ST_LOADED = 2'd0,
    ST_FULL   = 2'd1,
    ST_GIVEN  = 2'd2,
    ST_NONE   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_KEY_MODE  = 2'd0,
    REG_KEY_LEN   = 2'd1,
    REG_DROP_DUPS = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic load;
    logic sort_start;
    logic pass_begin;
    logic take_first;
    logic sort_read;
    logic sort_final;
    logic sort_step;
    logic dd_begin;
    logic dd_read;
    logic dd_step;
    logic dd_finish;
    logic fetch_begin;
    logic fetch_read;
    logic fetch_out;
    logic fetch_none;
  } cmd_t;

  typedef struct packed {
    logic sorted;
    logic out_free;
    logic m_lt2;
    logic cnt_lt2;
    logic j_eq_m;
    logic j_eq_cnt;
    logic fptr_end;
    logic drop;
  } stat_t;

  // Map a key to an unsigned value whose order is the key order.
  function automatic logic [KEY_W-1:0] order_value(input logic [KEY_W-1:0] k,
                                                   input logic mode,
                                                   input logic [3:0] len);
    logic [KEY_W-1:0] kz;
    logic [3:0]       ls;
    logic [6:0]       sh;
    kz = k;
    ls = (len > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : len;
    sh = {ls, 3'b000};
    if (mode) begin
      if (k[KEY_W-2:0] == '0) begin
        kz = '0;
      end
      order_value = kz[KEY_W-1] ? ~kz : (kz | {1'b1, {(KEY_W-1){1'b0}}});
    end else begin
      order_value = k & ~({KEY_W{1'b1}} >> sh);
    end
  endfunction

endpackage

FILE: sv/ksu_datapath.sv
// ----------------------------------------------------------------------------
// ksu_datapath: entry store, sort/compact registers and result register
// One-write one-read entry memory with registered read data, bubble pass
// carry register, counters and the output word.
// ----------------------------------------------------------------------------
module ksu_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ksu_pkg::cmd_t                cmd,
  output ksu_pkg::stat_t               stat,
  input  logic                         key_mode,
  input  logic [3:0]                   key_len,
  input  logic                         drop_dups,
  input  logic [ksu_pkg::REC_W-1:0]    in_rec,
  input  logic [ksu_pkg::KEY_W-1:0]    in_key,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [1:0]                   out_status,
  output logic [ksu_pkg::REC_W-1:0]    out_rec,
  output logic [ksu_pkg::KEY_W-1:0]    out_key,
  output logic                         out_last
);

  localparam int CW = ksu_pkg::CNT_W;
  localparam int IW = ksu_pkg::IDX_W;

  logic [ksu_pkg::ENT_W-1:0] mem [ksu_pkg::MAX_ENTRIES];
  logic [ksu_pkg::ENT_W-1:0] rdata_r, cur_r, cur_nxt, wd;
  logic [CW-1:0] cnt_r, cnt_nxt, fptr_r, fptr_nxt, m_r, m_nxt, j_r, j_nxt, eff_cnt;
  logic [CW-1:0] wa_c, ra_c;
  logic          sorted_r, sorted_nxt, we, re, full, gt, key_ne;
  logic [ksu_pkg::KEY_W-1:0] ov_cur, ov_rd;
  logic          ov_r, ov_nxt;
  logic [1:0]    os_r, os_nxt;
  logic [ksu_pkg::REC_W-1:0] orec_r, orec_nxt;
  logic [ksu_pkg::KEY_W-1:0] okey_r, okey_nxt;
  logic          olast_r, olast_nxt;

  assign ov_cur = ksu_pkg::order_value(cur_r[ksu_pkg::KEY_W-1:0], key_mode, key_len);
  assign ov_rd  = ksu_pkg::order_value(rdata_r[ksu_pkg::KEY_W-1:0], key_mode, key_len);
  assign key_ne = (ov_cur != ov_rd);
  assign gt     = (ov_cur > ov_rd) ||
                  ((ov_cur == ov_rd) &&
                   (cur_r[ksu_pkg::ENT_W-1:ksu_pkg::KEY_W] >
                    rdata_r[ksu_pkg::ENT_W-1:ksu_pkg::KEY_W]));

  assign eff_cnt = sorted_r ? '0 : cnt_r;
  assign full    = (eff_cnt == CW'(ksu_pkg::MAX_ENTRIES));

  always_comb begin
    we = 1'b0; wa_c = '0; wd = rdata_r;
    re = 1'b0; ra_c = '0;
    cnt_nxt = cnt_r; fptr_nxt = fptr_r; sorted_nxt = sorted_r;
    m_nxt = m_r; j_nxt = j_r; cur_nxt = cur_r;
    ov_nxt = ov_r && !out_ready;
    os_nxt = os_r; orec_nxt = orec_r; okey_nxt = okey_r; olast_nxt = olast_r;
    if (cmd.load) begin
      sorted_nxt = 1'b0;
      fptr_nxt   = '0;
      ov_nxt = 1'b1; orec_nxt = '0; okey_nxt = '0; olast_nxt = 1'b0;
      if (full) begin
        os_nxt  = ksu_pkg::ST_FULL;
        cnt_nxt = eff_cnt;
      end else begin
        os_nxt  = ksu_pkg::ST_LOADED;
        we = 1'b1; wa_c = eff_cnt; wd = {in_rec, in_key};
        cnt_nxt = eff_cnt + CW'(1);
      end
    end
    if (cmd.sort_start) m_nxt = cnt_r;
    if (cmd.pass_begin || cmd.dd_begin) begin
      re = 1'b1; ra_c = '0; j_nxt = CW'(1);
    end
    if (cmd.dd_begin) m_nxt = CW'(1);
    if (cmd.take_first) cur_nxt = rdata_r;
    if (cmd.sort_read || cmd.dd_read) begin
      re = 1'b1; ra_c = j_r;
    end
    if (cmd.sort_final) begin
      we = 1'b1; wa_c = m_r - CW'(1); wd = cur_r;
      m_nxt = m_r - CW'(1);
    end
    if (cmd.sort_step) begin
      we = 1'b1; wa_c = j_r - CW'(1);
      if (gt) begin
        wd = rdata_r;
      end else begin
        wd = cur_r; cur_nxt = rdata_r;
      end
      j_nxt = j_r + CW'(1);
    end
    if (cmd.dd_step) begin
      if (key_ne) begin
        we = 1'b1; wa_c = m_r; wd = rdata_r;
        cur_nxt = rdata_r; m_nxt = m_r + CW'(1);
      end
      j_nxt = j_r + CW'(1);
    end
    if (cmd.dd_finish) cnt_nxt = m_r;
    if (cmd.fetch_begin) begin
      sorted_nxt = 1'b1; fptr_nxt = '0;
    end
    if (cmd.fetch_read) begin
      re = 1'b1; ra_c = fptr_r;
    end
    if (cmd.fetch_out) begin
      ov_nxt = 1'b1; os_nxt = ksu_pkg::ST_GIVEN;
      orec_nxt = rdata_r[ksu_pkg::ENT_W-1:ksu_pkg::KEY_W];
      okey_nxt = rdata_r[ksu_pkg::KEY_W-1:0];
      olast_nxt = ((fptr_r + CW'(1)) == cnt_r);
      fptr_nxt = fptr_r + CW'(1);
    end
    if (cmd.fetch_none) begin
      ov_nxt = 1'b1; os_nxt = ksu_pkg::ST_NONE;
      orec_nxt = '0; okey_nxt = '0; olast_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa_c[IW-1:0]] <= wd;
    if (re) rdata_r <= mem[ra_c[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; fptr_r <= '0; sorted_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt; fptr_r <= fptr_nxt; sorted_r <= sorted_nxt; ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r <= m_nxt; j_r <= j_nxt; cur_r <= cur_nxt;
    os_r <= os_nxt; orec_r <= orec_nxt; okey_r <= okey_nxt; olast_r <= olast_nxt;
  end

  assign stat.sorted   = sorted_r;
  assign stat.out_free = !ov_r || out_ready;
  assign stat.m_lt2    = (m_r < CW'(2));
  assign stat.cnt_lt2  = (cnt_r < CW'(2));
  assign stat.j_eq_m   = (j_r == m_r);
  assign stat.j_eq_cnt = (j_r == cnt_r);
  assign stat.fptr_end = (fptr_r >= cnt_r);
  assign stat.drop     = drop_dups;

  assign out_valid  = ov_r;
  assign out_status = os_r;
  assign out_rec    = orec_r;
  assign out_key    = okey_r;
  assign out_last   = olast_r;

endmodule

FILE: sv/ksu_ctrl.sv
// ----------------------------------------------------------------------------
// ksu_ctrl: sequencer of the keyed entry sorter
// Accepts words, runs the bubble passes, the duplicate compaction and the
// fetch reads by issuing commands to the datapath.
// ----------------------------------------------------------------------------
module ksu_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_op,
  output logic           in_ready,
  input  ksu_pkg::stat_t stat,
  output ksu_pkg::cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_IDLE       = 9'b000000001,
    S_SORT_PASS  = 9'b000000010,
    S_SORT_FIRST = 9'b000000100,
    S_SORT_RD    = 9'b000001000,
    S_SORT_CMP   = 9'b000010000,
    S_DD_FIRST   = 9'b000100000,
    S_DD_RD      = 9'b001000000,
    S_DD_CHK     = 9'b010000000,
    S_FETCH_RD   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   fout_r, fout_nxt;

  assign in_ready = (state_r == S_IDLE) && !fout_r && stat.out_free;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    fout_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (fout_r) begin
          cmd.fetch_out = 1'b1;
        end else if (in_valid && in_ready) begin
          if (!in_op) begin
            cmd.load = 1'b1;
          end else if (stat.sorted) begin
            state_nxt = S_FETCH_RD;
          end else begin
            cmd.sort_start = 1'b1;
            state_nxt = S_SORT_PASS;
          end
        end
      end
      S_SORT_PASS: begin
        if (!stat.m_lt2) begin
          cmd.pass_begin = 1'b1;
          state_nxt = S_SORT_FIRST;
        end else if (stat.drop && !stat.cnt_lt2) begin
          cmd.dd_begin = 1'b1;
          state_nxt = S_DD_FIRST;
        end else begin
          cmd.fetch_begin = 1'b1;
          state_nxt = S_FETCH_RD;
        end
      end
      S_SORT_FIRST: begin
        cmd.take_first = 1'b1;
        state_nxt = S_SORT_RD;
      end
      S_SORT_RD: begin
        if (stat.j_eq_m) begin
          cmd.sort_final = 1'b1;
          state_nxt = S_SORT_PASS;
        end else begin
          cmd.sort_read = 1'b1;
          state_nxt = S_SORT_CMP;
        end
      end
      S_SORT_CMP: begin
        cmd.sort_step = 1'b1;
        state_nxt = S_SORT_RD;
      end
      S_DD_FIRST: begin
        cmd.take_first = 1'b1;
        state_nxt = S_DD_RD;
      end
      S_DD_RD: begin
        if (stat.j_eq_cnt) begin
          cmd.dd_finish = 1'b1;
          cmd.fetch_begin = 1'b1;
          state_nxt = S_FETCH_RD;
        end else begin
          cmd.dd_read = 1'b1;
          state_nxt = S_DD_CHK;
        end
      end
      S_DD_CHK: begin
        cmd.dd_step = 1'b1;
        state_nxt = S_DD_RD;
      end
      S_FETCH_RD: begin
        if (stat.fptr_end) begin
          cmd.fetch_none = 1'b1;
        end else begin
          cmd.fetch_read = 1'b1;
          fout_nxt = 1'b1;
        end
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fout_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fout_r  <= fout_nxt;
    end
  end

endmodule

FILE: sv/keyed_entry_sort_unique.sv
// A load answers in the cycle after acceptance; a fetch answers via the
// fetch-read state, the memory read, then the output word (straight from
// fetch-read when nothing is left). One load per cycle while the output
// word is free; no word is taken until a fetch has answered. The first fetch
// of a set first runs bubble passes over the one-write one-read entry memory
// and, with drop_dups, the compaction. Reset (rst_n, synchronous): empty store, loading phase, registers default.
// ----------------------------------------------------------------------------
// keyed_entry_sort_unique: top level of the keyed entry sorter
// Stream in (load/fetch), stream out (status words), APB register port.
// ----------------------------------------------------------------------------
module keyed_entry_sort_unique (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // [31:0] rec_id, [95:32] key
  input  logic        in_tuser,   // [0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // [31:0] out_record, [95:32] out_key
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic           key_mode_r, drop_r;
  logic [3:0]     key_len_r;
  logic           wr_en;
  ksu_pkg::cmd_t  cmd;
  ksu_pkg::stat_t stat;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Register writes land at the access cycle; unused addresses drop.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_mode_r <= 1'b0;
      key_len_r  <= 4'(ksu_pkg::KEY_BYTES);
      drop_r     <= 1'b0;
    end else if (wr_en) begin
      unique case (cfg_paddr[3:2])
        ksu_pkg::REG_KEY_MODE:  key_mode_r <= cfg_pwdata[0];
        ksu_pkg::REG_KEY_LEN:   key_len_r  <= cfg_pwdata[3:0];
        ksu_pkg::REG_DROP_DUPS: drop_r     <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      ksu_pkg::REG_KEY_MODE:  cfg_prdata = {31'd0, key_mode_r};
      ksu_pkg::REG_KEY_LEN:   cfg_prdata = {28'd0, key_len_r};
      ksu_pkg::REG_DROP_DUPS: cfg_prdata = {31'd0, drop_r};
      default:                cfg_prdata = '0;
    endcase
  end

  ksu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_op    (in_tuser),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ksu_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .key_mode   (key_mode_r),
    .key_len    (key_len_r),
    .drop_dups  (drop_r),
    .in_rec     (in_tdata[31:0]),
    .in_key     (in_tdata[95:32]),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_status (out_tuser),
    .out_rec    (out_tdata[31:0]),
    .out_key    (out_tdata[95:32]),
    .out_last   (out_tlast)
  );

endmodule
